FILE: src/lfc_pkg.sv
// Shared types and constants for the letter-frequency language classifier.
`timescale 1ns / 1ps

package lfc_pkg;

  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int COUNT_BITS_DEF    = 16;
  localparam int FRAC_BITS_DEF     = 10;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef enum logic [1:0] {
    KIND_LOAD_EN = 2'd0,
    KIND_LOAD_FR = 2'd1,
    KIND_TEXT    = 2'd2,
    KIND_END     = 2'd3
  } lfc_kind_t;

  typedef struct packed {
    lfc_kind_t   kind;
    logic [4:0]  letter_index;
    logic [10:0] expected_value;
    logic [7:0]  text_byte;
  } lfc_in_t;

  typedef struct packed {
    logic        is_english;
    logic [15:0] letter_total;
    logic        overflowed;
  } lfc_out_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic is_english;
  } lfc_scan_status_t;

endpackage

FILE: src/lfc_count_mem.sv
// Per-letter count memory with read-modify-write increment and scan-and-clear port.
`timescale 1ns / 1ps

module lfc_count_mem #(
  parameter int ALPHABET_SIZE = lfc_pkg::ALPHABET_SIZE_DEF,
  parameter int COUNT_BITS    = lfc_pkg::COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic inc_en,
  input  logic [((ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1)-1:0] inc_idx,
  input  logic scan_en,
  input  logic [((ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1)-1:0] scan_idx,
  output logic [COUNT_BITS-1:0] scan_count
);

  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  logic [COUNT_BITS-1:0] mem [ALPHABET_SIZE];
  logic [COUNT_BITS-1:0] rdata;

  logic [ALPHABET_SIZE-1:0] live;
  logic                     rd_live;
  logic [COUNT_BITS-1:0]    rd_count;

  logic          s1_valid;
  logic [AW-1:0] s1_idx;
  logic          fwd_valid;
  logic [AW-1:0] fwd_idx;
  logic [COUNT_BITS-1:0] fwd_data;

  logic [AW-1:0]         raddr;
  logic                  ren;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] new_count;

  assign raddr = scan_en ? scan_idx : inc_idx;
  assign ren   = scan_en | inc_en;

  // entries not written since reset read as zero
  assign rd_count = rd_live ? rdata : '0;

  // Previous write landed at the same edge as this entry's read: take it from the bypass.
  assign cur_count = (fwd_valid && (fwd_idx == s1_idx)) ? fwd_data : rd_count;
  assign new_count = cur_count + COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata   <= mem[raddr];
      rd_live <= live[raddr];
    end
    if (s1_valid) begin
      mem[s1_idx] <= new_count;
    end else if (scan_en) begin
      mem[scan_idx] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      live      <= '0;
    end else begin
      s1_valid  <= inc_en;
      fwd_valid <= s1_valid;
      if (s1_valid) begin
        live[s1_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx   <= inc_idx;
    fwd_idx  <= s1_idx;
    fwd_data <= new_count;
  end

  assign scan_count = rd_count;

`ifndef SYNTHESIS
  a_no_scan_during_inc: assert property (@(posedge clk) disable iff (rst)
    !(scan_en && (s1_valid || inc_en)))
    else $error("count scan overlaps an increment");
`endif

endmodule

FILE: src/lfc_table_mem.sv
// Expected-frequency memory holding the English and French entries side by side.
`timescale 1ns / 1ps

module lfc_table_mem #(
  parameter int ALPHABET_SIZE = lfc_pkg::ALPHABET_SIZE_DEF,
  parameter int FRAC_BITS     = lfc_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic wr_en,
  input  logic wr_fr,
  input  logic [((ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1)-1:0] wr_idx,
  input  logic [FRAC_BITS:0] wr_val,
  input  logic rd_en,
  input  logic [((ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1)-1:0] rd_idx,
  output logic [FRAC_BITS:0] rd_en_val,
  output logic [FRAC_BITS:0] rd_fr_val
);

  localparam int EW = FRAC_BITS + 1;

  logic [2*EW-1:0] mem [ALPHABET_SIZE];
  logic [2*EW-1:0] rd_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_fr) begin
        mem[wr_idx][2*EW-1:EW] <= wr_val;
      end else begin
        mem[wr_idx][EW-1:0] <= wr_val;
      end
    end
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  assign rd_en_val = rd_q[EW-1:0];
  assign rd_fr_val = rd_q[2*EW-1:EW];

endmodule

FILE: src/lfc_scorer.sv
// Distance sequencer: walks the letters with one shared multiplier and two accumulators.
`timescale 1ns / 1ps

module lfc_scorer #(
  parameter int ALPHABET_SIZE = lfc_pkg::ALPHABET_SIZE_DEF,
  parameter int COUNT_BITS    = lfc_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS     = lfc_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic out_free,
  input  logic [COUNT_BITS-1:0] total,
  input  logic [COUNT_BITS-1:0] cnt_rd,
  input  logic [FRAC_BITS:0]    exp_en_rd,
  input  logic [FRAC_BITS:0]    exp_fr_rd,
  output logic scan_rd_en,
  output logic [((ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1)-1:0] scan_idx,
  output lfc_pkg::lfc_scan_status_t status
);

  import lfc_pkg::*;

  localparam int AW    = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int DW    = COUNT_BITS + FRAC_BITS + 1;
  localparam int PW    = 2 * DW;
  localparam int ACC_W = PW + $clog2(ALPHABET_SIZE + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_YE   = 8'b0000_0100,
    S_YF   = 8'b0000_1000,
    S_SE   = 8'b0001_0000,
    S_SF   = 8'b0010_0000,
    S_ACC  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } scan_state_t;

  scan_state_t state, state_next;
  logic [AW-1:0]    idx;
  logic [DW-1:0]    x;
  logic [DW-1:0]    de;
  logic [DW-1:0]    df;
  logic [PW-1:0]    prod;
  logic [ACC_W-1:0] acc_e;
  logic [ACC_W-1:0] acc_f;

  logic [DW-1:0] mul_a;
  logic [DW-1:0] mul_b;
  logic [PW-1:0] mul_p;
  logic [DW-1:0] prod_lo;
  logic [DW-1:0] diff;
  logic          last;

  assign last = (idx == AW'(ALPHABET_SIZE - 1));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_YE: begin
        mul_a = DW'(exp_en_rd);
        mul_b = DW'(total);
      end
      S_YF: begin
        mul_a = DW'(exp_fr_rd);
        mul_b = DW'(total);
      end
      S_SE: begin
        mul_a = de;
        mul_b = de;
      end
      S_SF: begin
        mul_a = df;
        mul_b = df;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // expected * total always fits the low half
  assign prod_lo = prod[DW-1:0];
  assign diff    = (x >= prod_lo) ? (x - prod_lo) : (prod_lo - x);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_RD;
      S_RD:   state_next = S_YE;
      S_YE:   state_next = S_YF;
      S_YF:   state_next = S_SE;
      S_SE:   state_next = S_SF;
      S_SF:   state_next = S_ACC;
      S_ACC:  state_next = last ? S_DONE : S_RD;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        idx <= '0;
      end else if (state == S_ACC && !last) begin
        idx <= idx + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (start) begin
      acc_e <= '0;
      acc_f <= '0;
    end
    case (state)
      S_YE:  x     <= DW'(cnt_rd) << FRAC_BITS;
      S_YF:  de    <= diff;
      S_SE:  df    <= diff;
      S_SF:  acc_e <= acc_e + ACC_W'(prod);
      S_ACC: acc_f <= acc_f + ACC_W'(prod);
      default: ;
    endcase
  end

  assign scan_rd_en        = (state == S_RD);
  assign scan_idx          = idx;
  assign status.busy       = (state != S_IDLE);
  assign status.done       = (state == S_DONE) && out_free;
  assign status.is_english = (acc_e < acc_f);

`ifndef SYNTHESIS
  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == S_IDLE))
    else $error("scan started while busy");
`endif

endmodule

FILE: src/letter_frequency_language_classifier.sv
// Top level of the letter-frequency language classifier.
`timescale 1ns / 1ps

// Counts letters of a byte stream case-insensitively against two loaded
// expected-frequency tables (English, French, Q1.FRAC_BITS) and on an end
// transaction returns English only if its squared distance is strictly
// smaller, then clears the counts. Table loads and text bytes are taken one
// per cycle while no end transaction is in progress; a letter is counted
// through a read-modify-write of the count memory with a bypass for repeated
// letters. An end transaction occupies the block while it scans all letters:
// per letter one memory read, which also clears that letter's count, four
// products on the single shared multiplier and the accumulates. Input ready
// returns once the result is in the output register. The total saturates at
// 2^COUNT_BITS-1; later letters are dropped and flagged as overflowed.

module letter_frequency_language_classifier #(
  parameter int ALPHABET_SIZE = lfc_pkg::ALPHABET_SIZE_DEF,
  parameter int COUNT_BITS    = lfc_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS     = lfc_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lfc_pkg::lfc_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lfc_pkg::lfc_out_t out_data
);

  import lfc_pkg::*;

  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  lfc_scan_status_t status;

  logic [COUNT_BITS-1:0] total;
  logic                  overflow;

  logic       accept;
  logic [7:0] folded;
  logic [7:0] letter_pos;
  logic       counted;
  logic       inc_en;
  logic       tab_wr;
  logic       start;
  logic       out_free;

  logic                  scan_rd_en;
  logic [AW-1:0]         scan_idx;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [FRAC_BITS:0]    exp_en_rd;
  logic [FRAC_BITS:0]    exp_fr_rd;

  assign in_ready = !status.busy;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign folded = (in_data.text_byte >= CHAR_LOWER_A && in_data.text_byte <= CHAR_LOWER_Z)
                  ? (in_data.text_byte - CASE_OFFSET) : in_data.text_byte;
  assign letter_pos = folded - CHAR_UPPER_A;
  assign counted = (folded >= CHAR_UPPER_A) && (folded <= CHAR_UPPER_Z) &&
                   (letter_pos < 8'(ALPHABET_SIZE));

  assign inc_en = accept && (in_data.kind == KIND_TEXT) && counted && (total != COUNT_MAX);
  assign tab_wr = accept &&
                  ((in_data.kind == KIND_LOAD_EN) || (in_data.kind == KIND_LOAD_FR)) &&
                  ({1'b0, in_data.letter_index} < 6'(ALPHABET_SIZE));
  assign start  = accept && (in_data.kind == KIND_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (status.done) begin
        total     <= '0;
        overflow  <= 1'b0;
        out_valid <= 1'b1;
      end else begin
        if (out_ready) begin
          out_valid <= 1'b0;
        end
        if (inc_en) begin
          total <= total + COUNT_BITS'(1);
        end else if (accept && in_data.kind == KIND_TEXT && counted) begin
          overflow <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      out_data.is_english   <= status.is_english;
      out_data.letter_total <= 16'(total);
      out_data.overflowed   <= overflow;
    end
  end

  lfc_count_mem #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_BITS    (COUNT_BITS)
  ) u_count_mem (
    .clk        (clk),
    .rst        (rst),
    .inc_en     (inc_en),
    .inc_idx    (AW'(letter_pos)),
    .scan_en    (scan_rd_en),
    .scan_idx   (scan_idx),
    .scan_count (cnt_rd)
  );

  lfc_table_mem #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .FRAC_BITS     (FRAC_BITS)
  ) u_table_mem (
    .clk       (clk),
    .wr_en     (tab_wr),
    .wr_fr     (in_data.kind == KIND_LOAD_FR),
    .wr_idx    (AW'(in_data.letter_index)),
    .wr_val    ((FRAC_BITS + 1)'(in_data.expected_value)),
    .rd_en     (scan_rd_en),
    .rd_idx    (scan_idx),
    .rd_en_val (exp_en_rd),
    .rd_fr_val (exp_fr_rd)
  );

  lfc_scorer #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_BITS    (COUNT_BITS),
    .FRAC_BITS     (FRAC_BITS)
  ) u_scorer (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .out_free   (out_free),
    .total      (total),
    .cnt_rd     (cnt_rd),
    .exp_en_rd  (exp_en_rd),
    .exp_fr_rd  (exp_fr_rd),
    .scan_rd_en (scan_rd_en),
    .scan_idx   (scan_idx),
    .status     (status)
  );

`ifndef SYNTHESIS
  a_saturate_flags: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.kind == KIND_TEXT && counted && total == COUNT_MAX)
    |=> (overflow && total == COUNT_MAX))
    else $error("saturated letter not flagged");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    status.done |=> (out_valid && total == '0 && !overflow))
    else $error("result transaction did not clear the text state");
`endif

endmodule

FILE: bench/language_verdict_checker.sv
// Scoreboard for the classifier: tracks letter counts and tables, predicts and checks verdicts.
`timescale 1ns / 1ps

module language_verdict_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  lfc_pkg::lfc_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  lfc_pkg::lfc_out_t out_data,
  output int                mismatches,
  output int                awaiting,
  output int                verdicts,
  output int                english_votes
);

  import lfc_pkg::*;

  localparam int LETTERS = ALPHABET_SIZE_DEF;
  localparam int FRAC    = FRAC_BITS_DEF;
  localparam logic [COUNT_BITS_DEF-1:0] TOTAL_CEILING = '1;

  logic [COUNT_BITS_DEF-1:0] letter_tally [LETTERS];
  logic [COUNT_BITS_DEF-1:0] tally_sum;
  logic                      dropped;
  logic [FRAC_BITS_DEF:0]    english_freq [LETTERS];
  logic [FRAC_BITS_DEF:0]    french_freq [LETTERS];
  lfc_out_t                  verdict_q [$];
  int err_count     = 0;
  int verdict_count = 0;
  int english_count = 0;

  // sum of (count*2^FRAC - expected*total)^2, held exactly
  function automatic logic [127:0] squared_distance(input bit french);
    logic [127:0] acc, x, y, d;
    int i;
    acc = '0;
    for (i = 0; i < LETTERS; i++) begin
      x = letter_tally[i];
      x = x << FRAC;
      y = french ? french_freq[i] : english_freq[i];
      y = y * tally_sum;
      d = (x > y) ? x - y : y - x;
      acc = acc + d * d;
    end
    return acc;
  endfunction

  task automatic clear_tally();
    int i;
    for (i = 0; i < LETTERS; i++) letter_tally[i] = '0;
    tally_sum = '0;
    dropped   = 1'b0;
  endtask

  task automatic absorb(input lfc_in_t item);
    logic [7:0] ch;
    int         li;
    lfc_out_t   want;
    case (item.kind)
      KIND_LOAD_EN: begin
        if (item.letter_index < LETTERS) english_freq[item.letter_index] = item.expected_value;
      end
      KIND_LOAD_FR: begin
        if (item.letter_index < LETTERS) french_freq[item.letter_index] = item.expected_value;
      end
      KIND_TEXT: begin
        ch = item.text_byte;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) ch = ch - CASE_OFFSET;
        li = ch - CHAR_UPPER_A;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z && li < LETTERS) begin
          if (tally_sum == TOTAL_CEILING) begin
            dropped = 1'b1;
          end else begin
            letter_tally[li] = letter_tally[li] + 1'b1;
            tally_sum        = tally_sum + 1'b1;
          end
        end
      end
      KIND_END: begin
        // ties and empty texts fall to French
        want.is_english   = squared_distance(1'b0) < squared_distance(1'b1);
        want.letter_total = tally_sum;
        want.overflowed   = dropped;
        verdict_q.push_back(want);
        clear_tally();
      end
      default: ;
    endcase
  endtask

  task automatic judge(input lfc_out_t got);
    lfc_out_t want;
    if (verdict_q.size() == 0) begin
      $error("unexpected result transaction: is_english %0d letter_total %0d overflowed %0d",
             got.is_english, got.letter_total, got.overflowed);
      err_count++;
    end else begin
      want = verdict_q.pop_front();
      verdict_count++;
      if (want.is_english) english_count++;
      if (got.is_english !== want.is_english) begin
        $error("is_english: expected %0d, actual %0d", want.is_english, got.is_english);
        err_count++;
      end
      if (got.letter_total !== want.letter_total) begin
        $error("letter_total: expected %0d, actual %0d", want.letter_total, got.letter_total);
        err_count++;
      end
      if (got.overflowed !== want.overflowed) begin
        $error("overflowed: expected %0d, actual %0d", want.overflowed, got.overflowed);
        err_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_tally();
      verdict_q.delete();
    end else begin
      if (in_valid && in_ready) absorb(in_data);
      if (out_valid && out_ready) judge(out_data);
    end
    mismatches    <= err_count;
    awaiting      <= verdict_q.size();
    verdicts      <= verdict_count;
    english_votes <= english_count;
  end

endmodule

FILE: bench/letter_frequency_language_classifier_tb.sv
// Testbench top: clock, reset, stimulus and verdict for the language classifier.
`timescale 1ns / 1ps

module letter_frequency_language_classifier_tb;
  import lfc_pkg::*;

  localparam int LETTERS     = ALPHABET_SIZE_DEF;
  localparam int SCAN_CYCLES = 6 * ALPHABET_SIZE_DEF + 1;
  localparam int LIMIT       = 600000;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  lfc_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lfc_out_t out_data;

  int mismatches, awaiting, verdicts, english_votes;
  int cycles    = 0;
  int sent      = 0;
  int ends_sent = 0;
  bit steady    = 1'b0;

  // rough letter frequencies in Q0.10
  int english_ref [LETTERS] = '{84, 15, 29, 44, 130, 23, 21, 62, 71, 2, 8, 41, 25,
                                69, 77, 20, 1, 61, 65, 93, 28, 10, 24, 2, 20, 1};
  int french_ref  [LETTERS] = '{78, 9, 33, 37, 150, 11, 10, 7, 77, 6, 0, 56, 30,
                                73, 55, 31, 14, 68, 81, 74, 65, 19, 0, 4, 3, 1};
  int en_tab [LETTERS];
  int fr_tab [LETTERS];

  letter_frequency_language_classifier u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  language_verdict_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatches    (mismatches),
    .awaiting      (awaiting),
    .verdicts      (verdicts),
    .english_votes (english_votes)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= LIMIT);
    $display("letter_frequency_language_classifier regression: fail");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) out_ready <= !rst && (steady || $urandom_range(99) >= 34);

  task automatic send(input lfc_in_t item);
    while (!steady && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic load_entry(input lfc_kind_t kind, input int idx, input int val);
    lfc_in_t item;
    item.kind           = kind;
    item.letter_index   = idx[4:0];
    item.expected_value = val[10:0];
    item.text_byte      = 8'($urandom_range(255));
    send(item);
    if (idx < LETTERS) begin
      if (kind == KIND_LOAD_EN) en_tab[idx] = val;
      else fr_tab[idx] = val;
    end
  endtask

  task automatic send_text(input logic [7:0] b);
    lfc_in_t item;
    item.kind           = KIND_TEXT;
    item.letter_index   = 5'($urandom_range(25));
    item.expected_value = 11'($urandom_range(1024));
    item.text_byte      = b;
    send(item);
  endtask

  task automatic close_text();
    lfc_in_t item;
    item.kind           = KIND_END;
    item.letter_index   = 5'($urandom_range(25));
    item.expected_value = 11'($urandom_range(1024));
    item.text_byte      = 8'($urandom_range(255));
    send(item);
    ends_sent++;
  endtask

  task automatic send_string(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_text(s[i]);
  endtask

  function automatic logic [7:0] letter_byte(input int li);
    logic [7:0] b;
    b = CHAR_UPPER_A + li[7:0];
    if ($urandom_range(1)) b = b + CASE_OFFSET;
    return b;
  endfunction

  // draw a letter with the odds of one loaded table
  function automatic int pick_letter(input bit french);
    int total, r, i;
    total = 0;
    for (i = 0; i < LETTERS; i++) total += french ? fr_tab[i] : en_tab[i];
    if (total == 0) return $urandom_range(LETTERS - 1);
    r = $urandom_range(total - 1);
    for (i = 0; i < LETTERS; i++) begin
      r -= french ? fr_tab[i] : en_tab[i];
      if (r < 0) return i;
    end
    return LETTERS - 1;
  endfunction

  initial begin : stimulus
    int  i, n, base, len, ends_base, pick;
    bit  french;
    lfc_kind_t kind;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // identical tables first: any text is a tie
    for (i = 0; i < LETTERS; i++) begin
      load_entry(KIND_LOAD_EN, i, english_ref[i]);
      load_entry(KIND_LOAD_FR, i, english_ref[i]);
    end
    close_text();
    send_string("ab");
    close_text();
    for (i = 0; i < LETTERS; i++) load_entry(KIND_LOAD_FR, i, french_ref[i]);

    // loads past the alphabet are dropped
    load_entry(KIND_LOAD_EN, 26, 1024);
    load_entry(KIND_LOAD_FR, 31, 0);
    send_string("tHe wHich");
    close_text();
    send_text(8'h00); send_text(8'hFF); send_text(8'h80); send_text(8'h40);
    send_text(8'h5B); send_text(8'h60); send_text(8'h7B); send_text(8'h7F);
    send_string("AZaz");
    close_text();
    load_entry(KIND_LOAD_EN, 16, 1024);
    load_entry(KIND_LOAD_FR, 16, 0);
    send_string("qQ");
    close_text();

    // saturate the letter total, then a few dropped letters
    steady = 1'b1;
    for (n = 0; n < 65538; n++) send_text(letter_byte($urandom_range(LETTERS - 1)));
    close_text();
    steady = 1'b0;

    base      = sent;
    ends_base = ends_sent;
    while (sent - base < 800 || ends_sent - ends_base < 40) begin
      steady = (sent - base >= 300) && (sent - base < 420);
      pick   = $urandom_range(99);
      if (pick < 8) begin
        kind = $urandom_range(1) ? KIND_LOAD_FR : KIND_LOAD_EN;
        i    = ($urandom_range(9) == 0) ? $urandom_range(31, 26) : $urandom_range(25);
        case ($urandom_range(5))
          0:       n = 0;
          1:       n = 1024;
          2:       n = $urandom_range(1024);
          default: n = $urandom_range(160);
        endcase
        load_entry(kind, i, n);
      end else if (pick < 16) begin
        len = $urandom_range(6, 1);
        for (n = 0; n < len; n++) send_text(8'($urandom_range(255)));
      end else begin
        french = 1'($urandom_range(1));
        len    = $urandom_range(30);
        for (n = 0; n < len; n++) begin
          if ($urandom_range(9) == 0) send_text(8'($urandom_range(255)));
          else send_text(letter_byte(pick_letter(french)));
        end
        close_text();
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SCAN_CYCLES + 40) @(posedge clk);

    $display("Drove %0d input transactions over %0d texts, one past the letter-total ceiling.",
             sent, ends_sent);
    $display("Checked %0d verdicts (%0d English) incl. empty text, tie and ignored loads/bytes.",
             verdicts, english_votes);
    if (mismatches == 0) begin
      $display("letter_frequency_language_classifier regression: pass");
    end else begin
      $display("letter_frequency_language_classifier regression: fail");
    end
    $finish;
  end

endmodule
